### sv/agla_pkg.sv
package agla_pkg;

    localparam int SCORE_IN_W  = 16;
    localparam int GAP_W       = 16;
    localparam int SIZE_W      = 11;
    localparam int OUT_IDX_W   = 11;
    localparam int TOP_SCORE_W = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FIFO_DEPTH  = 4;

    localparam logic signed [31:0] NEG_INF = 32'sh8000_0000;
    localparam logic signed [31:0] SAT_HI  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_LO  = 32'sh8000_0001;
    localparam logic signed [32:0] SUM_HI  = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] SUM_LO  = 33'sh1_8000_0001;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_EXTEND  = 2'd3;

    localparam logic [SIZE_W-1:0] RST_QUERY_ROWS  = 11'd1;
    localparam logic [SIZE_W-1:0] RST_TARGET_COLS = 11'd1;
    localparam logic [GAP_W-1:0]  RST_GAP_OPEN    = 16'hF600;
    localparam logic [GAP_W-1:0]  RST_GAP_EXTEND  = 16'hFF00;

    localparam logic [1:0] FROM_RESTART = 2'd0;
    localparam logic [1:0] FROM_MATCH   = 2'd1;
    localparam logic [1:0] FROM_INSERT  = 2'd2;
    localparam logic [1:0] FROM_DELETE  = 2'd3;

    localparam logic GAP_OPENED   = 1'b0;
    localparam logic GAP_EXTENDED = 1'b1;

    localparam logic [1:0] STATE_STOP   = 2'd0;
    localparam logic [1:0] STATE_MATCH  = 2'd1;
    localparam logic [1:0] STATE_INSERT = 2'd2;
    localparam logic [1:0] STATE_DELETE = 2'd3;

    typedef struct packed {
        logic first_row;
        logic last_col;
        logic grid_done;
    } cell_flags_t;

    typedef struct packed {
        logic signed [31:0] m;
        logic signed [31:0] i;
        logic signed [31:0] d;
    } triple_t;

    function automatic logic signed [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (a == NEG_INF)
        begin
            r = NEG_INF;
        end
        else if (s > SUM_HI)
        begin
            r = SAT_HI;
        end
        else if (s < SUM_LO)
        begin
            r = SAT_LO;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

### sv/affine_gap_local_alignment.sv
// Channel   Direction  Handshake                  Payload
// cell      in         cell_valid / cell_stall    cell_score
// result    out        result_valid / result_stall match_from .. top_state
// cfg       in         cfg_write                  cfg_index, cfg_data
//
// One cell per clock sustained while result_stall is low; a result passes the queue, the
// compute, local max and tracker stages and the output register. The rate is set by the
// left-neighbor loop in the compute stage and the one-read row memory.
// rst_n clears counters, queue, pipeline valids and tracker; the row memory is not cleared.
// result_stall freezes the back pipeline; cell_stall rises once the 4-entry queue fills.
module affine_gap_local_alignment #(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_QUERY  = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cell_valid,
    output logic                                  cell_stall,
    input  logic [agla_pkg::SCORE_IN_W-1:0]       cell_score,
    input  logic                                  cfg_write,
    input  logic [agla_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [agla_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [1:0]                            match_from,
    output logic                                  insert_from,
    output logic                                  delete_from,
    output logic                                  grid_done,
    output logic [agla_pkg::TOP_SCORE_W-1:0]      top_score,
    output logic signed [agla_pkg::OUT_IDX_W-1:0] top_row,
    output logic signed [agla_pkg::OUT_IDX_W-1:0] top_col,
    output logic [1:0]                            top_state
);

    localparam int RW = $clog2(MAX_QUERY);
    localparam int CW = $clog2(MAX_TARGET);
    localparam int ITEM_W = agla_pkg::SCORE_IN_W + RW + CW + $bits(agla_pkg::cell_flags_t);

    logic                       queue_full;
    logic                       push;
    logic [ITEM_W-1:0]          push_data;
    logic                       pop;
    logic                       head_valid;
    logic [ITEM_W-1:0]          head_data;
    logic [agla_pkg::GAP_W-1:0] gap_open;
    logic [agla_pkg::GAP_W-1:0] gap_extend;

    agla_front #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_QUERY  (MAX_QUERY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_score (cell_score),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data),
        .gap_open   (gap_open),
        .gap_extend (gap_extend)
    );

    agla_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (head_valid),
        .pop_data  (head_data)
    );

    agla_back #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_QUERY  (MAX_QUERY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .gap_open     (gap_open),
        .gap_extend   (gap_extend),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .match_from   (match_from),
        .insert_from  (insert_from),
        .delete_from  (delete_from),
        .grid_done    (grid_done),
        .top_score    (top_score),
        .top_row      (top_row),
        .top_col      (top_col),
        .top_state    (top_state)
    );

endmodule

### sv/agla_fifo.sv
module agla_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(agla_pkg::FIFO_DEPTH);

    logic [WIDTH-1:0] store_reg [agla_pkg::FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full      = count_reg == (PW+1)'(agla_pkg::FIFO_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_reg != '0)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

### sv/agla_front.sv
module agla_front #(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_QUERY  = 1024,
    localparam int RW = $clog2(MAX_QUERY),
    localparam int CW = $clog2(MAX_TARGET),
    localparam int ITEM_W = agla_pkg::SCORE_IN_W + RW + CW + $bits(agla_pkg::cell_flags_t)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cell_valid,
    output logic                                cell_stall,
    input  logic [agla_pkg::SCORE_IN_W-1:0]     cell_score,
    input  logic                                cfg_write,
    input  logic [agla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [agla_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                queue_full,
    output logic                                push,
    output logic [ITEM_W-1:0]                   push_data,
    output logic [agla_pkg::GAP_W-1:0]          gap_open,
    output logic [agla_pkg::GAP_W-1:0]          gap_extend
);

    logic [agla_pkg::SIZE_W-1:0] query_rows_reg;
    logic [agla_pkg::SIZE_W-1:0] target_cols_reg;
    logic [agla_pkg::GAP_W-1:0]  gap_open_reg;
    logic [agla_pkg::GAP_W-1:0]  gap_extend_reg;
    logic [RW-1:0]               row_reg;
    logic [RW-1:0]               row_next;
    logic [CW-1:0]               col_reg;
    logic [CW-1:0]               col_next;
    logic [31:0]                 rows_eff;
    logic [31:0]                 cols_eff;
    logic                        last_row;
    agla_pkg::cell_flags_t       flags;

    assign cell_stall = queue_full;
    assign push       = cell_valid && !queue_full;
    assign push_data  = {cell_score, row_reg, col_reg, flags};
    assign gap_open   = gap_open_reg;
    assign gap_extend = gap_extend_reg;

    always_comb
    begin
        rows_eff = 32'(query_rows_reg);
        if (query_rows_reg == '0)
        begin
            rows_eff = 32'd1;
        end
        else if (rows_eff > 32'(MAX_QUERY))
        begin
            rows_eff = 32'(MAX_QUERY);
        end

        cols_eff = 32'(target_cols_reg);
        if (target_cols_reg == '0)
        begin
            cols_eff = 32'd1;
        end
        else if (cols_eff > 32'(MAX_TARGET))
        begin
            cols_eff = 32'(MAX_TARGET);
        end

        last_row        = (32'(row_reg) + 32'd1) >= rows_eff;
        flags.first_row = row_reg == '0;
        flags.last_col  = (32'(col_reg) + 32'd1) >= cols_eff;
        flags.grid_done = flags.last_col && last_row;

        row_next = row_reg;
        col_next = col_reg + 1'b1;
        if (flags.last_col)
        begin
            col_next = '0;
            row_next = flags.grid_done ? '0 : row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_rows_reg  <= agla_pkg::RST_QUERY_ROWS;
            target_cols_reg <= agla_pkg::RST_TARGET_COLS;
            gap_open_reg    <= agla_pkg::RST_GAP_OPEN;
            gap_extend_reg  <= agla_pkg::RST_GAP_EXTEND;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                agla_pkg::REG_QUERY_ROWS:  query_rows_reg  <= cfg_data[agla_pkg::SIZE_W-1:0];
                agla_pkg::REG_TARGET_COLS: target_cols_reg <= cfg_data[agla_pkg::SIZE_W-1:0];
                agla_pkg::REG_GAP_OPEN:    gap_open_reg    <= cfg_data;
                agla_pkg::REG_GAP_EXTEND:  gap_extend_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && flags.grid_done) |=> (row_reg == '0 && col_reg == '0))
        else $error("grid counters not restarted after last cell");
`endif

endmodule

### sv/agla_back.sv
module agla_back #(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_QUERY  = 1024,
    localparam int RW = $clog2(MAX_QUERY),
    localparam int CW = $clog2(MAX_TARGET),
    localparam int ITEM_W = agla_pkg::SCORE_IN_W + RW + CW + $bits(agla_pkg::cell_flags_t)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  head_valid,
    input  logic [ITEM_W-1:0]                     head_data,
    output logic                                  pop,
    input  logic [agla_pkg::GAP_W-1:0]            gap_open,
    input  logic [agla_pkg::GAP_W-1:0]            gap_extend,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [1:0]                            match_from,
    output logic                                  insert_from,
    output logic                                  delete_from,
    output logic                                  grid_done,
    output logic [agla_pkg::TOP_SCORE_W-1:0]      top_score,
    output logic signed [agla_pkg::OUT_IDX_W-1:0] top_row,
    output logic signed [agla_pkg::OUT_IDX_W-1:0] top_col,
    output logic [1:0]                            top_state
);

    localparam int OW = agla_pkg::OUT_IDX_W;

    logic [agla_pkg::SCORE_IN_W-1:0] h_score;
    logic [RW-1:0]                   h_row;
    logic [CW-1:0]                   h_col;
    agla_pkg::cell_flags_t           h_flags;
    logic                            adv;
    logic                            b1_fire;

    agla_pkg::triple_t row_mem [MAX_TARGET];

    // compute stage
    logic                            b1_valid_reg;
    logic [agla_pkg::SCORE_IN_W-1:0] b1_score_reg;
    logic [RW-1:0]                   b1_row_reg;
    logic [CW-1:0]                   b1_col_reg;
    agla_pkg::cell_flags_t           b1_flags_reg;
    agla_pkg::triple_t               up_mem_reg;
    agla_pkg::triple_t               up_byp_reg;
    logic                            up_sel_reg;
    logic signed [31:0]              left_match_reg;
    logic signed [31:0]              left_delete_reg;
    agla_pkg::triple_t               diag_reg;

    agla_pkg::triple_t up;
    agla_pkg::triple_t new_cell;
    logic signed [31:0] pred;
    logic signed [31:0] go;
    logic signed [31:0] ge;
    logic signed [31:0] open_sum;
    logic signed [31:0] ext_sum;
    logic signed [31:0] dopen_sum;
    logic signed [31:0] dext_sum;
    logic [1:0]         mfrom;
    logic               ifrom;
    logic               dfrom;

    // local maximum stage
    logic               b2_valid_reg;
    agla_pkg::triple_t  b2_cell_reg;
    logic [1:0]         b2_mfrom_reg;
    logic               b2_ifrom_reg;
    logic               b2_dfrom_reg;
    logic [RW-1:0]      b2_row_reg;
    logic [CW-1:0]      b2_col_reg;
    logic               b2_done_reg;
    logic signed [31:0] lmax;
    logic [1:0]         lstate;

    // tracker stage
    logic               b3_valid_reg;
    logic signed [31:0] b3_max_reg;
    logic [1:0]         b3_state_reg;
    logic [1:0]         b3_mfrom_reg;
    logic               b3_ifrom_reg;
    logic               b3_dfrom_reg;
    logic [RW-1:0]      b3_row_reg;
    logic [CW-1:0]      b3_col_reg;
    logic               b3_done_reg;

    logic signed [31:0] best_score_reg;
    logic [OW-1:0]      best_row_reg;
    logic [OW-1:0]      best_col_reg;
    logic [1:0]         best_state_reg;
    logic signed [31:0] best_score_next;
    logic [OW-1:0]      best_row_next;
    logic [OW-1:0]      best_col_next;
    logic [1:0]         best_state_next;
    logic [31:0]        row_wide;
    logic [31:0]        col_wide;

    // output stage
    logic                             out_valid_reg;
    logic [1:0]                       out_mfrom_reg;
    logic                             out_ifrom_reg;
    logic                             out_dfrom_reg;
    logic                             out_done_reg;
    logic [agla_pkg::TOP_SCORE_W-1:0] out_score_reg;
    logic [OW-1:0]                    out_row_reg;
    logic [OW-1:0]                    out_col_reg;
    logic [1:0]                       out_state_reg;

    assign {h_score, h_row, h_col, h_flags} = head_data;
    assign adv     = !out_valid_reg || !result_stall;
    assign pop     = adv && head_valid;
    assign b1_fire = adv && b1_valid_reg;

    assign result_valid = out_valid_reg;
    assign match_from   = out_mfrom_reg;
    assign insert_from  = out_ifrom_reg;
    assign delete_from  = out_dfrom_reg;
    assign grid_done    = out_done_reg;
    assign top_score    = out_score_reg;
    assign top_row      = out_row_reg;
    assign top_col      = out_col_reg;
    assign top_state    = out_state_reg;

    always_comb
    begin
        if (b1_flags_reg.first_row)
        begin
            up.m = '0;
            up.i = agla_pkg::NEG_INF;
            up.d = agla_pkg::NEG_INF;
        end
        else
        begin
            up = up_sel_reg ? up_byp_reg : up_mem_reg;
        end

        go = agla_pkg::sext16(gap_open);
        ge = agla_pkg::sext16(gap_extend);

        pred  = '0;
        mfrom = agla_pkg::FROM_RESTART;
        if (diag_reg.m > pred)
        begin
            pred  = diag_reg.m;
            mfrom = agla_pkg::FROM_MATCH;
        end
        if (diag_reg.i > pred)
        begin
            pred  = diag_reg.i;
            mfrom = agla_pkg::FROM_INSERT;
        end
        if (diag_reg.d > pred)
        begin
            pred  = diag_reg.d;
            mfrom = agla_pkg::FROM_DELETE;
        end
        new_cell.m = agla_pkg::sat_add(agla_pkg::sext16(b1_score_reg), pred);

        open_sum = agla_pkg::sat_add(up.m, go);
        ext_sum  = agla_pkg::sat_add(up.i, ge);
        if (ext_sum > open_sum)
        begin
            new_cell.i = ext_sum;
            ifrom      = agla_pkg::GAP_EXTENDED;
        end
        else
        begin
            new_cell.i = open_sum;
            ifrom      = agla_pkg::GAP_OPENED;
        end

        dopen_sum = agla_pkg::sat_add(left_match_reg, go);
        dext_sum  = agla_pkg::sat_add(left_delete_reg, ge);
        if (dext_sum > dopen_sum)
        begin
            new_cell.d = dext_sum;
            dfrom      = agla_pkg::GAP_EXTENDED;
        end
        else
        begin
            new_cell.d = dopen_sum;
            dfrom      = agla_pkg::GAP_OPENED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_fire)
        begin
            row_mem[b1_col_reg] <= new_cell;
        end
        if (adv)
        begin
            up_mem_reg <= row_mem[h_col];
        end
    end

    always_comb
    begin
        lmax   = b2_cell_reg.m;
        lstate = agla_pkg::STATE_MATCH;
        if (b2_cell_reg.i > lmax)
        begin
            lmax   = b2_cell_reg.i;
            lstate = agla_pkg::STATE_INSERT;
        end
        if (b2_cell_reg.d > lmax)
        begin
            lmax   = b2_cell_reg.d;
            lstate = agla_pkg::STATE_DELETE;
        end
    end

    always_comb
    begin
        row_wide        = 32'(b3_row_reg);
        col_wide        = 32'(b3_col_reg);
        best_score_next = best_score_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        best_state_next = best_state_reg;
        if (b3_max_reg > best_score_reg)
        begin
            best_score_next = b3_max_reg;
            best_row_next   = row_wide[OW-1:0];
            best_col_next   = col_wide[OW-1:0];
            best_state_next = b3_state_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_score_reg <= h_score;
            b1_row_reg   <= h_row;
            b1_col_reg   <= h_col;
            b1_flags_reg <= h_flags;
            up_byp_reg   <= new_cell;
            up_sel_reg   <= b1_valid_reg && (h_col == b1_col_reg);

            b2_cell_reg  <= new_cell;
            b2_mfrom_reg <= mfrom;
            b2_ifrom_reg <= ifrom;
            b2_dfrom_reg <= dfrom;
            b2_row_reg   <= b1_row_reg;
            b2_col_reg   <= b1_col_reg;
            b2_done_reg  <= b1_flags_reg.grid_done;

            b3_max_reg   <= lmax;
            b3_state_reg <= lstate;
            b3_mfrom_reg <= b2_mfrom_reg;
            b3_ifrom_reg <= b2_ifrom_reg;
            b3_dfrom_reg <= b2_dfrom_reg;
            b3_row_reg   <= b2_row_reg;
            b3_col_reg   <= b2_col_reg;
            b3_done_reg  <= b2_done_reg;

            out_mfrom_reg <= b3_mfrom_reg;
            out_ifrom_reg <= b3_ifrom_reg;
            out_dfrom_reg <= b3_dfrom_reg;
            out_done_reg  <= b3_done_reg;
            out_score_reg <= best_score_next[agla_pkg::TOP_SCORE_W-1:0];
            out_row_reg   <= best_row_next;
            out_col_reg   <= best_col_next;
            out_state_reg <= best_state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg    <= 1'b0;
            b2_valid_reg    <= 1'b0;
            b3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            left_match_reg  <= '0;
            left_delete_reg <= agla_pkg::NEG_INF;
            diag_reg.m      <= '0;
            diag_reg.i      <= agla_pkg::NEG_INF;
            diag_reg.d      <= agla_pkg::NEG_INF;
            best_score_reg  <= '0;
            best_row_reg    <= '1;
            best_col_reg    <= '1;
            best_state_reg  <= agla_pkg::STATE_STOP;
        end
        else
        begin
            if (adv)
            begin
                b1_valid_reg  <= head_valid;
                b2_valid_reg  <= b1_valid_reg;
                b3_valid_reg  <= b2_valid_reg;
                out_valid_reg <= b3_valid_reg;
            end
            if (b1_fire)
            begin
                if (b1_flags_reg.last_col)
                begin
                    left_match_reg  <= '0;
                    left_delete_reg <= agla_pkg::NEG_INF;
                    diag_reg.m      <= '0;
                    diag_reg.i      <= agla_pkg::NEG_INF;
                    diag_reg.d      <= agla_pkg::NEG_INF;
                end
                else
                begin
                    left_match_reg  <= new_cell.m;
                    left_delete_reg <= new_cell.d;
                    diag_reg        <= up;
                end
            end
            if (adv && b3_valid_reg)
            begin
                if (b3_done_reg)
                begin
                    best_score_reg <= '0;
                    best_row_reg   <= '1;
                    best_col_reg   <= '1;
                    best_state_reg <= agla_pkg::STATE_STOP;
                end
                else
                begin
                    best_score_reg <= best_score_next;
                    best_row_reg   <= best_row_next;
                    best_col_reg   <= best_col_next;
                    best_state_reg <= best_state_next;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (b1_fire && b1_flags_reg.last_col)
        |=> (left_match_reg == '0 && left_delete_reg == agla_pkg::NEG_INF))
        else $error("left neighbor not cleared at row end");
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && b3_valid_reg && b3_done_reg)
        |=> (best_score_reg == '0 && best_row_reg == '1 && best_col_reg == '1))
        else $error("best tracker not cleared after last cell");
`endif

endmodule
